// File: design/msr_pkg.sv
package msr_pkg;

   // Default configuration, handed to the top level's parameters.
   localparam int unsigned NUM_AXES_DEF     = 6;
   localparam int unsigned MOVE_DIVISOR_DEF = 10;
   localparam int unsigned MAX_SPEED_DEF    = 10;

   // Field widths.
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned AXIS_W  = 3;
   localparam int unsigned PULSE_W = 11;
   localparam int unsigned SPEED_W = 4;
   localparam int unsigned STEP_W  = 5;

   // Stream word layout.
   localparam int unsigned REQ_DATA_W     = 24;
   localparam int unsigned REQ_AXIS_LSB   = 0;
   localparam int unsigned REQ_TARGET_LSB = REQ_AXIS_LSB + AXIS_W;
   localparam int unsigned REQ_SPEED_LSB  = REQ_TARGET_LSB + PULSE_W;
   localparam int unsigned RSP_DATA_W     = 16;
   localparam int unsigned RSP_AXIS_LSB   = 0;
   localparam int unsigned RSP_PULSE_LSB  = RSP_AXIS_LSB + AXIS_W;
   localparam int unsigned RSP_PAD_W      = RSP_DATA_W - AXIS_W - PULSE_W;

   // Pulse width limits in microseconds.
   localparam logic [PULSE_W-1:0] POS_RESET = 11'd1500;
   localparam logic [PULSE_W-1:0] POS_MIN   = 11'd1000;
   localparam logic [PULSE_W-1:0] POS_MAX   = 11'd2000;
   localparam logic [STEP_W-1:0]  STEP_MAX  = 5'd31;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_MOVE   = 2'd0,
      CMD_PAUSE  = 2'd1,
      CMD_RESUME = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   // One command as it waits in the queue; the speed is already inverted.
   typedef struct packed {
      cmd_type             cmd;
      logic [AXIS_W-1:0]   axis;
      logic [PULSE_W-1:0]  target;
      logic [SPEED_W-1:0]  inv_speed;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic      avail;
      entry_type entry;
   } q_head_type;

   typedef struct packed {
      logic               start;
      logic [PULSE_W-1:0] dividend;
      logic [PULSE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [PULSE_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_COUNT,
      BK_DIV_STEP,
      BK_TICK
   } back_state_type;

endpackage

// File: design/msr_front.sv
module msr_front #(
   parameter int unsigned NUM_AXES  = msr_pkg::NUM_AXES_DEF,
   parameter int unsigned MAX_SPEED = msr_pkg::MAX_SPEED_DEF
) (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [msr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [msr_pkg::CMD_W-1:0]          req_tuser,
   input  logic                               q_full,
   output msr_pkg::q_push_type                q_push
);

   localparam logic [msr_pkg::AXIS_W+1:0]  AXIS_LIMIT = (msr_pkg::AXIS_W + 2)'(NUM_AXES);
   localparam logic [msr_pkg::SPEED_W-1:0] SPEED_TOP  = msr_pkg::SPEED_W'(MAX_SPEED);
   localparam logic [msr_pkg::SPEED_W:0]   INV_BASE   = (msr_pkg::SPEED_W + 1)'(MAX_SPEED + 1);

   msr_pkg::cmd_type                cmd;
   logic [msr_pkg::AXIS_W-1:0]      axis;
   logic [msr_pkg::PULSE_W-1:0]     target;
   logic [msr_pkg::SPEED_W-1:0]     speed;
   logic                            axis_ok;
   logic                            move_ok;
   logic                            keep;

   always_comb begin
      cmd     = msr_pkg::cmd_type'(req_tuser);
      axis    = req_tdata[msr_pkg::REQ_AXIS_LSB +: msr_pkg::AXIS_W];
      target  = req_tdata[msr_pkg::REQ_TARGET_LSB +: msr_pkg::PULSE_W];
      speed   = req_tdata[msr_pkg::REQ_SPEED_LSB +: msr_pkg::SPEED_W];
      axis_ok = {2'b00, axis} < AXIS_LIMIT;
      move_ok = axis_ok && (target >= msr_pkg::POS_MIN) && (target <= msr_pkg::POS_MAX) &&
                (speed != '0) && (speed <= SPEED_TOP);
      // Commands that address a missing axis or carry a bad move are dropped here.
      unique case (cmd)
         msr_pkg::CMD_MOVE:                       keep = move_ok;
         msr_pkg::CMD_PAUSE, msr_pkg::CMD_RESUME: keep = axis_ok;
         msr_pkg::CMD_TICK:                       keep = 1'b1;
         default:                                 keep = 1'b0;
      endcase
   end

   assign req_tready = !q_full;

   always_comb begin
      q_push.push            = req_tvalid && !q_full && keep;
      q_push.entry.cmd       = cmd;
      q_push.entry.axis      = axis;
      q_push.entry.target    = target;
      q_push.entry.inv_speed = msr_pkg::SPEED_W'(INV_BASE - {1'b0, speed});
   end

endmodule

// File: design/msr_fifo.sv
module msr_fifo #(
   parameter int unsigned DEPTH = msr_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  msr_pkg::q_push_type q_push,
   output logic                q_full,
   output msr_pkg::q_head_type q_head,
   input  logic                q_pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   FULL_COUNT = (PTR_W + 1)'(DEPTH);

   msr_pkg::entry_type slot_ff [DEPTH];
   msr_pkg::entry_type slot_in [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      do_push   = q_push.push && (count_ff != FULL_COUNT);
      do_pop    = q_pop && (count_ff != '0);
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         slot_in[wr_ptr_ff] = q_push.entry;
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign q_full       = (count_ff == FULL_COUNT);
   assign q_head.avail = (count_ff != '0);
   assign q_head.entry = slot_ff[rd_ptr_ff];

endmodule

// File: design/msr_div.sv
module msr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  msr_pkg::div_req_type div_req,
   output msr_pkg::div_rsp_type div_rsp
);

   localparam int unsigned W     = msr_pkg::PULSE_W;
   localparam int unsigned CNT_W = $clog2(W + 1);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(W - 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W:0]       shifted;
   logic [W:0]       diff;
   logic             fits;

   // Restoring division, one quotient bit per cycle. The dividend shifts out of
   // the quotient register while quotient bits shift in behind it.
   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[W-1:0] : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: design/msr_back.sv
module msr_back #(
   parameter int unsigned NUM_AXES     = msr_pkg::NUM_AXES_DEF,
   parameter int unsigned MOVE_DIVISOR = msr_pkg::MOVE_DIVISOR_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  msr_pkg::q_head_type            q_head,
   output logic                           q_pop,
   output msr_pkg::div_req_type           div_req,
   input  msr_pkg::div_rsp_type           div_rsp,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int unsigned PW    = msr_pkg::PULSE_W;
   localparam int unsigned SW    = msr_pkg::SPEED_W;
   localparam int unsigned STW   = msr_pkg::STEP_W;
   localparam int unsigned IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_AXES - 1);
   // Rounded-up reciprocal of the move divisor, scaled so that the product
   // gives the exact quotient for every distance of PW bits.
   localparam int unsigned DIV_L   = $clog2(MOVE_DIVISOR);
   localparam int unsigned SHIFT   = PW + DIV_L;
   localparam int unsigned RECIP_V = ((32'd1 << SHIFT) + MOVE_DIVISOR - 1) / MOVE_DIVISOR;
   localparam logic [PW:0]       RECIP = (PW + 1)'(RECIP_V);

   // Per-axis state.
   logic [PW-1:0]  pos_ff    [NUM_AXES];
   logic [PW-1:0]  pos_in    [NUM_AXES];
   logic [PW-1:0]  tgt_ff    [NUM_AXES];
   logic [PW-1:0]  tgt_in    [NUM_AXES];
   logic [SW-1:0]  div_ff    [NUM_AXES];
   logic [SW-1:0]  div_in    [NUM_AXES];
   logic [STW-1:0] step_ff   [NUM_AXES];
   logic [STW-1:0] step_in   [NUM_AXES];
   logic [SW-1:0]  tc_ff     [NUM_AXES];
   logic [SW-1:0]  tc_in     [NUM_AXES];
   logic [NUM_AXES-1:0] moving_ff, moving_in;
   logic [NUM_AXES-1:0] up_ff, up_in;
   logic [NUM_AXES-1:0] paused_ff, paused_in;

   msr_pkg::back_state_type st_ff, st_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [NUM_AXES-1:0]     mask_ff, mask_in;
   msr_pkg::entry_type      cur_ff, cur_in;
   logic [PW-1:0]           dist_ff, dist_in;
   logic                    upw_ff, upw_in;

   logic                         out_valid_ff, out_valid_in;
   logic [msr_pkg::AXIS_W-1:0]   out_axis_ff, out_axis_in;
   logic [PW-1:0]                out_pulse_ff, out_pulse_in;
   logic                         out_last_ff, out_last_in;

   // Shared read port into the axis state.
   logic [IDX_W-1:0]    addr;
   logic [PW-1:0]       a_pos;
   logic [PW-1:0]       a_tgt;
   logic [SW-1:0]       a_div;
   logic [STW-1:0]      a_step;
   logic [SW-1:0]       a_tc;
   logic                a_up;
   logic                a_active;

   logic [NUM_AXES-1:0] step_now;
   logic [PW-1:0]       head_dist;
   logic                head_up;
   logic                skip_move;
   logic [PW-1:0]       walk_rem;
   logic                walk_snap;
   logic [PW-1:0]       walk_pos;
   logic                walk_step;
   logic                walk_last;
   logic                out_free;
   logic                walk_hold;
   logic [2*PW:0]       cnt_prod;
   logic [PW-1:0]       cnt_quo;
   logic [PW-1:0]       move_cnt;
   logic [STW-1:0]      quo_step;

   logic do_move_start;
   logic do_div2_start;
   logic do_commit;
   logic do_flag_write;
   logic do_tick_start;
   logic do_walk;

   // ---------------------------------------------------------------- datapath views
   always_comb begin
      unique case (st_ff)
         msr_pkg::BK_TICK: addr = idx_ff;
         msr_pkg::BK_IDLE: addr = IDX_W'(q_head.entry.axis);
         default:          addr = IDX_W'(cur_ff.axis);
      endcase
      a_pos    = pos_ff[addr];
      a_tgt    = tgt_ff[addr];
      a_div    = div_ff[addr];
      a_step   = step_ff[addr];
      a_tc     = tc_ff[addr];
      a_up     = up_ff[addr];
      a_active = moving_ff[addr] && !paused_ff[addr];

      for (int i = 0; i < NUM_AXES; i++) begin
         step_now[i] = moving_ff[i] && !paused_ff[i] && ((tc_ff[i] + 1'b1) >= div_ff[i]);
      end

      head_up   = q_head.entry.target > a_pos;
      head_dist = head_up ? (q_head.entry.target - a_pos) : (a_pos - q_head.entry.target);
      // A move is dropped when already there, or already heading there at this speed.
      skip_move = (q_head.entry.target == a_pos) ||
                  ((q_head.entry.target == a_tgt) && (q_head.entry.inv_speed == a_div));

      walk_rem  = (a_pos > a_tgt) ? (a_pos - a_tgt) : (a_tgt - a_pos);
      walk_snap = walk_rem <= PW'(a_step);
      if (walk_snap) begin
         walk_pos = a_tgt;
      end else if (a_up) begin
         walk_pos = a_pos + PW'(a_step);
      end else begin
         walk_pos = a_pos - PW'(a_step);
      end
      walk_step = mask_ff[idx_ff];
      walk_last = (mask_ff & ~(NUM_AXES'(1) << idx_ff)) == '0;

      out_free  = !out_valid_ff || rsp_tready;
      walk_hold = walk_step && !out_free;

      // The move count is the distance over the move divisor, taken by multiplying
      // with the reciprocal; a count of zero is raised to one.
      cnt_prod = (2*PW + 1)'(dist_ff) * (2*PW + 1)'(RECIP);
      cnt_quo  = PW'(cnt_prod >> SHIFT);
      move_cnt = (cnt_quo == '0) ? PW'(1) : cnt_quo;
      quo_step = (div_rsp.quotient > PW'(msr_pkg::STEP_MAX)) ? msr_pkg::STEP_MAX :
                 div_rsp.quotient[STW-1:0];
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         msr_pkg::BK_IDLE: begin
            if (q_head.avail) begin
               unique case (q_head.entry.cmd)
                  msr_pkg::CMD_MOVE: st_in = skip_move ? msr_pkg::BK_IDLE :
                                                         msr_pkg::BK_DIV_COUNT;
                  msr_pkg::CMD_TICK: st_in = msr_pkg::BK_TICK;
                  default:           st_in = msr_pkg::BK_IDLE;
               endcase
            end
         end
         msr_pkg::BK_DIV_COUNT: begin
            st_in = msr_pkg::BK_DIV_STEP;
         end
         msr_pkg::BK_DIV_STEP: begin
            if (div_rsp.done) st_in = msr_pkg::BK_IDLE;
         end
         msr_pkg::BK_TICK: begin
            if (!walk_hold && (idx_ff == LAST_IDX)) st_in = msr_pkg::BK_IDLE;
         end
         default: st_in = msr_pkg::BK_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- state outputs
   always_comb begin
      q_pop         = 1'b0;
      do_move_start = 1'b0;
      do_div2_start = 1'b0;
      do_commit     = 1'b0;
      do_flag_write = 1'b0;
      do_tick_start = 1'b0;
      do_walk       = 1'b0;
      unique case (st_ff)
         msr_pkg::BK_IDLE: begin
            q_pop = q_head.avail;
            if (q_head.avail) begin
               case (q_head.entry.cmd) inside
                  msr_pkg::CMD_MOVE:                       do_move_start = !skip_move;
                  msr_pkg::CMD_PAUSE, msr_pkg::CMD_RESUME: do_flag_write = 1'b1;
                  default:                                 do_tick_start = 1'b1;
               endcase
            end
         end
         msr_pkg::BK_DIV_COUNT: do_div2_start = 1'b1;
         msr_pkg::BK_DIV_STEP:  do_commit     = div_rsp.done;
         msr_pkg::BK_TICK:      do_walk       = !walk_hold;
         default: ;
      endcase
   end

   always_comb begin
      div_req.start    = do_div2_start;
      div_req.dividend = dist_ff;
      div_req.divisor  = move_cnt;
   end

   // ---------------------------------------------------------------- register updates
   always_comb begin
      pos_in       = pos_ff;
      tgt_in       = tgt_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      tc_in        = tc_ff;
      moving_in    = moving_ff;
      up_in        = up_ff;
      paused_in    = paused_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      cur_in       = cur_ff;
      dist_in      = dist_ff;
      upw_in       = upw_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_axis_in  = out_axis_ff;
      out_pulse_in = out_pulse_ff;
      out_last_in  = out_last_ff;

      if (do_move_start) begin
         cur_in  = q_head.entry;
         dist_in = head_dist;
         upw_in  = head_up;
      end

      if (do_flag_write) begin
         paused_in[addr] = (q_head.entry.cmd == msr_pkg::CMD_PAUSE);
      end

      if (do_commit) begin
         paused_in[addr] = 1'b0;
         tgt_in[addr]    = cur_ff.target;
         div_in[addr]    = cur_ff.inv_speed;
         step_in[addr]   = quo_step;
         tc_in[addr]     = '0;
         moving_in[addr] = 1'b1;
         up_in[addr]     = upw_ff;
      end

      // The step mask is fixed when the tick starts so the final write is known.
      if (do_tick_start) begin
         mask_in = step_now;
         idx_in  = '0;
      end

      // Each visited axis leaves the mask, so only axes still ahead count
      // against the final write.
      if (do_walk) begin
         idx_in          = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         mask_in[idx_ff] = 1'b0;
         if (a_active) begin
            tc_in[addr] = walk_step ? '0 : a_tc + 1'b1;
         end
         if (walk_step) begin
            pos_in[addr] = walk_pos;
            if (walk_snap) moving_in[addr] = 1'b0;
            out_valid_in = 1'b1;
            out_axis_in  = msr_pkg::AXIS_W'(idx_ff);
            out_pulse_in = walk_pos;
            out_last_in  = walk_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            pos_ff[i]  <= msr_pkg::POS_RESET;
            tgt_ff[i]  <= '0;
            div_ff[i]  <= '0;
            step_ff[i] <= '0;
            tc_ff[i]   <= '0;
         end
         moving_ff    <= '0;
         up_ff        <= '0;
         paused_ff    <= '0;
         st_ff        <= msr_pkg::BK_IDLE;
         idx_ff       <= '0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
         div_ff       <= div_in;
         step_ff      <= step_in;
         tc_ff        <= tc_in;
         moving_ff    <= moving_in;
         up_ff        <= up_in;
         paused_ff    <= paused_in;
         st_ff        <= st_in;
         idx_ff       <= idx_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      dist_ff      <= dist_in;
      upw_ff       <= upw_in;
      out_axis_ff  <= out_axis_in;
      out_pulse_ff <= out_pulse_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{msr_pkg::RSP_PAD_W{1'b0}}, out_pulse_ff, out_axis_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: design/multi_axis_servo_ramp_top.sv
// A tick word is registered in the queue before the back end sees it; its first pulse
// write then passes the back end's tick state and its output register.
// A tick holds the back end while it walks the axes in turn, a move that is carried out
// while it takes the move count and then waits on the bit-serial divider for the step
// size; any other word is handled in the idle state.
// Up to four words queue ahead of the back end, so input keeps flowing while it works.
// Reset (synchronous, active high) empties the queue and output register and returns
// every axis to 1500 us, idle and unpaused.
module multi_axis_servo_ramp_top #(
   parameter int unsigned NUM_AXES     = msr_pkg::NUM_AXES_DEF,
   parameter int unsigned MOVE_DIVISOR = msr_pkg::MOVE_DIVISOR_DEF,
   parameter int unsigned MAX_SPEED    = msr_pkg::MAX_SPEED_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Command words. tdata from bit 0: axis (3), target_us (11), speed_level (4), zero pad.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [msr_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: command (2): move, pause, resume or tick.
   input  logic [msr_pkg::CMD_W-1:0]      req_tuser,
   // Pulse width writes. tdata from bit 0: out_axis (3), pulse_us (11), zero pad.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tlast marks the final write caused by one tick.
   output logic                           rsp_tlast
);

   msr_pkg::q_push_type  q_push;
   msr_pkg::q_head_type  q_head;
   msr_pkg::div_req_type div_req;
   msr_pkg::div_rsp_type div_rsp;
   logic                 q_full;
   logic                 q_pop;

   // The front end checks ranges, drops words that fail them and inverts
   // the speed, so the back end only sees commands that pass the checks.
   msr_front #(
      .NUM_AXES  (NUM_AXES),
      .MAX_SPEED (MAX_SPEED)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push)
   );

   // Short command queue between the two halves.
   msr_fifo #(
      .DEPTH (msr_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   // Divider for the step size of a move: the distance over the move count.
   msr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The back end holds the axis state, walks the axes on each tick one per cycle unless a
   // write waits on a full output register, and parks each pulse write in that register.
   msr_back #(
      .NUM_AXES     (NUM_AXES),
      .MOVE_DIVISOR (MOVE_DIVISOR)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/msr_checker.sv
module msr_checker #(
   parameter int unsigned NUM_AXES = msr_pkg::NUM_AXES_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [msr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   localparam logic [msr_pkg::AXIS_W+1:0] AXIS_LIMIT = (msr_pkg::AXIS_W + 2)'(NUM_AXES);

   logic [msr_pkg::PULSE_W-1:0] pulse;
   logic [msr_pkg::AXIS_W-1:0]  axis;

   assign pulse = rsp_tdata[msr_pkg::RSP_PULSE_LSB +: msr_pkg::PULSE_W];
   assign axis  = rsp_tdata[msr_pkg::RSP_AXIS_LSB +: msr_pkg::AXIS_W];

   // No write may survive a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("write word present right after reset");

   // A stalled write keeps its word.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled write word changed");

   // Ramps never leave the legal pulse range.
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pulse >= msr_pkg::POS_MIN) && (pulse <= msr_pkg::POS_MAX))
      else $error("pulse width outside the servo range");

   // Writes only name axes that exist.
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({2'b00, axis} < AXIS_LIMIT))
      else $error("write names a missing axis");

endmodule

bind multi_axis_servo_ramp_top msr_checker #(
   .NUM_AXES (NUM_AXES)
) u_msr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
